// File: sv/assert_macros.svh
// Assertion macros shared by the run-length texel expander RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define RPTT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be seen at a rising edge outside reset.
`define RPTT_NEVER(lbl, clk, rst, cond, msg) \
   `RPTT_ASSERT(lbl, clk, rst, !(cond), msg)

`endif

// File: sv/rptt_pkg.sv
// Package for the run-length palette to tiled texel expander.
// Constants, opcodes, status codes, queue entry type and tile addressing.
`timescale 1ns / 1ps

package rptt_pkg;

   localparam int TEXTURE_SIDE  = 64;
   localparam int PALETTE_DEPTH = 32;
   localparam int MAX_RUN       = 64;

   localparam int PAL_IDX_W  = $clog2(PALETTE_DEPTH);
   localparam int TILE_COLS  = TEXTURE_SIDE / 8;
   localparam int SIDE_LIMIT = (TEXTURE_SIDE < 64) ? TEXTURE_SIDE : 64;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [6:0] IMAGE_SIDE_RESET      = 7'd48;
   localparam logic [5:0] PALETTE_ENTRIES_RESET = 6'd22;

   // register index = paddr[2]
   localparam logic REG_IMAGE_SIDE      = 1'b0;
   localparam logic REG_PALETTE_ENTRIES = 1'b1;

   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_RUN    = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;
   localparam logic [1:0] OP_START  = 2'd3;

   localparam logic [2:0] ST_TEXEL      = 3'd0;
   localparam logic [2:0] ST_BAD_INDEX  = 3'd1;
   localparam logic [2:0] ST_OVERFLOW   = 3'd2;
   localparam logic [2:0] ST_COMPLETE   = 3'd3;
   localparam logic [2:0] ST_INCOMPLETE = 3'd4;

   // one classified item waiting for the back end
   typedef struct packed {
      logic [1:0]  op;
      logic [6:0]  count;   // already saturated to MAX_RUN
      logic        bad;     // index fails the palette range check
      logic [31:0] rgba;    // alpha high byte .. red low byte
   } cmd_type;

   // 8x8 tiles across the texture, Morton order inside a tile
   function automatic logic [11:0] tile_addr(input logic [5:0] x, input logic [5:0] y);
      logic [5:0]  swz;
      logic [31:0] tile;
      swz  = {y[2], x[2], y[1], x[1], y[0], x[0]};
      tile = 32'(y[5:3]) * 32'(TILE_COLS) + 32'(x[5:3]);
      return 12'((tile << 6) | 32'(swz));
   endfunction

endpackage

// File: sv/rptt_front.sv
// Front end: accepts items, holds the palette, classifies runs.
// Uses rptt_pkg; feeds rptt_fifo with rptt_pkg::cmd_type entries.
`timescale 1ns / 1ps

module rptt_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_op,
   input  logic [6:0]        req_run_length,
   input  logic [7:0]        req_color_index,
   input  logic [7:0]        req_entry_red,
   input  logic [7:0]        req_entry_green,
   input  logic [7:0]        req_entry_blue,
   input  logic [7:0]        req_entry_alpha,
   input  logic [5:0]        palette_entries,
   output logic              push_valid,
   output rptt_pkg::cmd_type push_cmd,
   input  logic              push_ready
);

   logic [31:0] palette_mem [rptt_pkg::PALETTE_DEPTH];

   logic        stg_valid_ff, stg_valid_in;
   logic [1:0]  stg_op_ff;
   logic [6:0]  stg_count_ff;
   logic        stg_bad_ff;
   logic [31:0] stg_rgba_ff;

   logic accept, push, idx_in_range, idx_bad;
   logic [6:0] count_sat;
   logic [rptt_pkg::PAL_IDX_W-1:0] idx;

   assign push      = stg_valid_ff && push_ready;
   assign req_ready = !stg_valid_ff || push;
   assign accept    = req_valid && req_ready;

   assign idx          = req_color_index[rptt_pkg::PAL_IDX_W-1:0];
   assign idx_in_range = {1'b0, req_color_index} < 9'(rptt_pkg::PALETTE_DEPTH);
   assign idx_bad      = !idx_in_range || (req_color_index >= {2'b00, palette_entries});
   assign count_sat    = (req_run_length > 7'(rptt_pkg::MAX_RUN)) ?
                         7'(rptt_pkg::MAX_RUN) : req_run_length;

   // palette writes end here; everything else goes on to the queue
   always_comb begin
      stg_valid_in = stg_valid_ff;
      if (accept && req_op != rptt_pkg::OP_WRITE) begin
         stg_valid_in = 1'b1;
      end else if (push) begin
         stg_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stg_op_ff    <= req_op;
         stg_count_ff <= count_sat;
         stg_bad_ff   <= idx_bad;
      end
   end

   // read before write: a run sees writes from earlier items only
   always_ff @(posedge clock) begin
      if (accept && req_op == rptt_pkg::OP_WRITE && idx_in_range) begin
         palette_mem[idx] <= {req_entry_alpha, req_entry_blue, req_entry_green, req_entry_red};
      end
      if (accept) begin
         stg_rgba_ff <= palette_mem[idx];
      end
   end

   assign push_valid = stg_valid_ff;
   always_comb begin
      push_cmd       = '0;
      push_cmd.op    = stg_op_ff;
      push_cmd.count = stg_count_ff;
      push_cmd.bad   = stg_bad_ff;
      push_cmd.rgba  = stg_rgba_ff;
   end

endmodule

// File: sv/rptt_fifo.sv
// Short command queue between front and back ends.
// Uses rptt_pkg (depth and entry type) and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rptt_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  rptt_pkg::cmd_type push_cmd,
   output logic              push_ready,
   output logic              pop_valid,
   output rptt_pkg::cmd_type pop_cmd,
   input  logic              pop_req
);

   rptt_pkg::cmd_type entry_ff [rptt_pkg::FIFO_DEPTH];

   logic [rptt_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rptt_pkg::FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rptt_pkg::FIFO_CNT_W-1:0] count_ff, count_in;
   logic push, pop;

   assign push_ready = count_ff != rptt_pkg::FIFO_CNT_W'(rptt_pkg::FIFO_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_req && pop_valid;
   assign pop_cmd    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == rptt_pkg::FIFO_PTR_W'(rptt_pkg::FIFO_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == rptt_pkg::FIFO_PTR_W'(rptt_pkg::FIFO_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `RPTT_NEVER(a_fifo_over, clock, reset, count_ff > rptt_pkg::FIFO_CNT_W'(rptt_pkg::FIFO_DEPTH), "queue occupancy past depth")
   `RPTT_ASSERT(a_fifo_ptr_gap, clock, reset, (count_ff == '0 || count_ff == rptt_pkg::FIFO_CNT_W'(rptt_pkg::FIFO_DEPTH)) |-> (wr_ptr_ff == rd_ptr_ff), "queue pointers disagree with occupancy")

endmodule

// File: sv/rptt_back.sv
// Back end: image counters, sticky error, run expansion, result register.
// Uses rptt_pkg (codes, tile_addr) and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rptt_back (
   input  logic              clock,
   input  logic              reset,
   input  logic [6:0]        image_side,
   input  logic              cmd_valid,
   input  rptt_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [11:0]       rsp_texel_offset,
   output logic [7:0]        rsp_red,
   output logic [7:0]        rsp_green,
   output logic [7:0]        rsp_blue,
   output logic [7:0]        rsp_alpha,
   output logic [2:0]        rsp_status,
   output logic              rsp_last
);

   logic [6:0]  side_ff, side_in;
   logic [12:0] total_ff;

   logic [5:0]  col_ff, col_in;
   logic [5:0]  row_ff, row_in;
   logic [12:0] done_ff, done_in;
   logic        err_ff, err_in;
   logic        busy_ff, busy_in;
   logic [6:0]  remain_ff, remain_in;
   logic [31:0] rgba_ff, rgba_in;

   logic        out_valid_ff, out_valid_in;
   logic [11:0] out_off_ff, out_off_in;
   logic [31:0] out_rgba_ff, out_rgba_in;
   logic [2:0]  out_status_ff, out_status_in;
   logic        out_last_ff, out_last_in;
   logic        load_out, out_free, overflow;

   // clamp side to 1..SIDE_LIMIT; area registered (config is quiet when idle)
   always_comb begin
      side_in = image_side;
      if (side_in == 7'd0) begin
         side_in = 7'd1;
      end else if (side_in > 7'(rptt_pkg::SIDE_LIMIT)) begin
         side_in = 7'(rptt_pkg::SIDE_LIMIT);
      end
   end

   always_ff @(posedge clock) begin
      side_ff  <= side_in;
      total_ff <= {6'd0, side_in} * {6'd0, side_in};
   end

   assign out_free = !out_valid_ff || rsp_ready;
   assign overflow = (14'(done_ff) + 14'(cmd.count)) > 14'(total_ff);

   always_comb begin
      col_in        = col_ff;
      row_in        = row_ff;
      done_in       = done_ff;
      err_in        = err_ff;
      busy_in       = busy_ff;
      remain_in     = remain_ff;
      rgba_in       = rgba_ff;
      cmd_pop       = 1'b0;
      load_out      = 1'b0;
      out_off_in    = '0;
      out_rgba_in   = '0;
      out_status_in = rptt_pkg::ST_TEXEL;
      out_last_in   = 1'b1;

      if (busy_ff) begin
         if (out_free) begin
            load_out    = 1'b1;
            out_off_in  = rptt_pkg::tile_addr(col_ff, row_ff);
            out_rgba_in = rgba_ff;
            out_last_in = remain_ff == 7'd1;
            done_in     = done_ff + 13'd1;
            if ({1'b0, col_ff} + 7'd1 >= side_ff) begin
               col_in = '0;
               row_in = row_ff + 6'd1;
            end else begin
               col_in = col_ff + 6'd1;
            end
            remain_in = remain_ff - 7'd1;
            if (remain_ff == 7'd1) begin
               busy_in = 1'b0;
            end
         end
      end else if (cmd_valid) begin
         unique case (cmd.op)
            rptt_pkg::OP_START: begin
               cmd_pop = 1'b1;
               col_in  = '0;
               row_in  = '0;
               done_in = '0;
               err_in  = 1'b0;
            end
            rptt_pkg::OP_FINISH: begin
               if (out_free) begin
                  cmd_pop       = 1'b1;
                  load_out      = 1'b1;
                  out_status_in = (!err_ff && done_ff == total_ff) ?
                                  rptt_pkg::ST_COMPLETE : rptt_pkg::ST_INCOMPLETE;
               end
            end
            rptt_pkg::OP_RUN: begin
               // both checks apply to empty runs too
               priority if (err_ff) begin
                  cmd_pop = 1'b1;
               end else if (cmd.bad || overflow) begin
                  if (out_free) begin
                     cmd_pop       = 1'b1;
                     load_out      = 1'b1;
                     err_in        = 1'b1;
                     out_status_in = cmd.bad ? rptt_pkg::ST_BAD_INDEX : rptt_pkg::ST_OVERFLOW;
                  end
               end else if (cmd.count == 7'd0) begin
                  cmd_pop = 1'b1;
               end else begin
                  cmd_pop   = 1'b1;
                  busy_in   = 1'b1;
                  remain_in = cmd.count;
                  rgba_in   = cmd.rgba;
               end
            end
            default: begin
               // palette writes stay in the front end
               cmd_pop = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         done_ff      <= '0;
         err_ff       <= 1'b0;
         busy_ff      <= 1'b0;
         remain_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         done_ff      <= done_in;
         err_ff       <= err_in;
         busy_ff      <= busy_in;
         remain_ff    <= remain_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rgba_ff <= rgba_in;
      if (load_out) begin
         out_off_ff    <= out_off_in;
         out_rgba_ff   <= out_rgba_in;
         out_status_ff <= out_status_in;
         out_last_ff   <= out_last_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_texel_offset = out_off_ff;
   assign rsp_red          = out_rgba_ff[7:0];
   assign rsp_green        = out_rgba_ff[15:8];
   assign rsp_blue         = out_rgba_ff[23:16];
   assign rsp_alpha        = out_rgba_ff[31:24];
   assign rsp_status       = out_status_ff;
   assign rsp_last         = out_last_ff;

   `RPTT_ASSERT(a_busy_remain, clock, reset, busy_ff |-> (remain_ff != 7'd0), "run in flight with no texels left")
   `RPTT_ASSERT(a_status_clean, clock, reset, (out_valid_ff && out_status_ff != rptt_pkg::ST_TEXEL) |-> (out_last_ff && out_off_ff == 12'd0 && out_rgba_ff == 32'd0), "status result carries texel data")
   `RPTT_ASSERT(a_pos_hold, clock, reset, (busy_ff && !out_free) |=> ($stable(col_ff) && $stable(row_ff) && $stable(done_ff)), "position moved while output stalled")
   `RPTT_NEVER(a_pop_empty, clock, reset, cmd_pop && !cmd_valid, "pop from empty queue")

endmodule

// File: sv/rle_palette_to_tiled_texels_core.sv
// Run-length palette expander writing texels into an 8x8 Morton-tiled texture.
// A run of n pixels (n clipped to MAX_RUN) that passes its checks is expanded to n texels,
// one texel a cycle while rsp_ready does not stall the output; palette writes never reach the back end.
// Path: front stage register, queue, back end, then the output register.
// Reset: counters, sticky error, queue and output cleared; image_side 48,
// palette_entries 22; palette contents are kept and stay undefined until written.
// Depends on rptt_pkg, rptt_front, rptt_fifo and rptt_back.
`timescale 1ns / 1ps

module rle_palette_to_tiled_texels_core (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [6:0]  req_run_length,
   input  logic [7:0]  req_color_index,
   input  logic [7:0]  req_entry_red,
   input  logic [7:0]  req_entry_green,
   input  logic [7:0]  req_entry_blue,
   input  logic [7:0]  req_entry_alpha,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_texel_offset,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic [2:0]  rsp_status,
   output logic        rsp_last,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // ---- registers: image_side at 0x0, palette_entries at 0x4 ----
   logic [6:0] image_side_ff;
   logic [5:0] palette_entries_ff;
   logic       csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_side_ff      <= rptt_pkg::IMAGE_SIDE_RESET;
         palette_entries_ff <= rptt_pkg::PALETTE_ENTRIES_RESET;
      end else if (csr_write) begin
         unique case (paddr[2])
            rptt_pkg::REG_IMAGE_SIDE:      image_side_ff      <= pwdata[6:0];
            rptt_pkg::REG_PALETTE_ENTRIES: palette_entries_ff <= pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         rptt_pkg::REG_IMAGE_SIDE:      prdata = {25'd0, image_side_ff};
         rptt_pkg::REG_PALETTE_ENTRIES: prdata = {26'd0, palette_entries_ff};
         default:                       prdata = '0;
      endcase
   end

   // ---- front end -> queue -> back end ----
   logic              push_valid, push_ready, pop_valid, pop_req;
   rptt_pkg::cmd_type push_cmd, pop_cmd;

   // front: palette store and item classification (index check, run clamp)
   rptt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_run_length  (req_run_length),
      .req_color_index (req_color_index),
      .req_entry_red   (req_entry_red),
      .req_entry_green (req_entry_green),
      .req_entry_blue  (req_entry_blue),
      .req_entry_alpha (req_entry_alpha),
      .palette_entries (palette_entries_ff),
      .push_valid      (push_valid),
      .push_cmd        (push_cmd),
      .push_ready      (push_ready)
   );

   // queue lets the front keep taking items while a run is expanding
   rptt_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_req    (pop_req)
   );

   // back: raster counters, sticky error, one texel per cycle into output reg while it is free
   rptt_back u_back (
      .clock            (clock),
      .reset            (reset),
      .image_side       (image_side_ff),
      .cmd_valid        (pop_valid),
      .cmd              (pop_cmd),
      .cmd_pop          (pop_req),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_texel_offset (rsp_texel_offset),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_alpha        (rsp_alpha),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

endmodule

// File: tb/tb.sv
// Self-checking testbench for rle_palette_to_tiled_texels_core: palette writes, runs,
// finish checks and image restarts go in; every texel and status item is checked.
// Depends on rptt_pkg and the core RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 11;
   // Slowest legal run: ~400 items, each up to 64 results, each result held back by
   // a random stall, plus a random gap before each item: well within CYCLE_LIMIT.
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_ITEMS  = 200;
   localparam int CLOSING_ITEMS = 30;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_REPORTS   = 20;

   // one result item as the block should produce it
   typedef struct {
      logic [11:0] offset;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [2:0]  status;
      logic        last;
   } texel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op = rptt_pkg::OP_FINISH;
   logic [6:0]  req_run_length = '0;
   logic [7:0]  req_color_index = '0;
   logic [7:0]  req_entry_red = '0;
   logic [7:0]  req_entry_green = '0;
   logic [7:0]  req_entry_blue = '0;
   logic [7:0]  req_entry_alpha = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [11:0] rsp_texel_offset;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [7:0]  rsp_alpha;
   logic [2:0]  rsp_status;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   rle_palette_to_tiled_texels_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_run_length   (req_run_length),
      .req_color_index  (req_color_index),
      .req_entry_red    (req_entry_red),
      .req_entry_green  (req_entry_green),
      .req_entry_blue   (req_entry_blue),
      .req_entry_alpha  (req_entry_alpha),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_texel_offset (rsp_texel_offset),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_alpha        (rsp_alpha),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ---------------------------------------------------------------------------
   // Shadow of the block: palette, raster position, pixel count, sticky error
   // and the two registers. Texels still owed by the block wait in texel_q.
   // ---------------------------------------------------------------------------
   logic [31:0] pal_rgba  [rptt_pkg::PALETTE_DEPTH];
   bit          pal_known [rptt_pkg::PALETTE_DEPTH];
   logic [5:0]  col_now = '0;
   logic [5:0]  row_now = '0;
   logic [12:0] done_now = '0;
   logic        err_now = 1'b0;
   logic [6:0]  side_reg = rptt_pkg::IMAGE_SIDE_RESET;
   logic [5:0]  entries_reg = rptt_pkg::PALETTE_ENTRIES_RESET;
   texel_type   texel_q [$];

   bit          idle_on = 1'b1;
   int          stall_left = 0;
   int          fail_count = 0;
   int          items_sent = 0;
   int          items_used = 0;   // items the block does not simply drop
   int          results_seen = 0;
   int          reg_writes = 0;
   int          cycle_count = 0;

   // side as the block uses it: 0 acts as 1, and it clips at the texture width
   function automatic int side_eff();
      int s;
      s = side_reg;
      if (s == 0) s = 1;
      if (s > 64) s = 64;
      if (s > rptt_pkg::TEXTURE_SIDE) s = rptt_pkg::TEXTURE_SIDE;
      return s;
   endfunction

   // 8x8 tiles in raster order, x/y bits interleaved (x in the even bits) inside a tile
   function automatic logic [11:0] swizzled_offset(logic [5:0] x, logic [5:0] y);
      logic [5:0] inner;
      int         tile;
      for (int b = 0; b < 3; b++) begin
         inner[2*b]   = x[b];
         inner[2*b+1] = y[b];
      end
      tile = int'(y >> 3) * (rptt_pkg::TEXTURE_SIDE / 8) + int'(x >> 3);
      return 12'(tile * 64 + int'(inner));
   endfunction

   function automatic void push_result(logic [11:0] off, logic [31:0] rgba,
                                       logic [2:0] st, logic fin);
      texel_type t;
      t.offset = off;
      t.red    = rgba[7:0];
      t.green  = rgba[15:8];
      t.blue   = rgba[23:16];
      t.alpha  = rgba[31:24];
      t.status = st;
      t.last   = fin;
      texel_q.push_back(t);
   endfunction

   // advance the shadow by one input item and queue what it must produce
   function automatic void predict_item(logic [1:0] op, logic [6:0] len, logic [7:0] idx,
                                        logic [31:0] rgba);
      int side;
      int total;
      int n;
      side  = side_eff();
      total = side * side;
      n     = len;
      case (op)
         rptt_pkg::OP_WRITE: begin
            // slots past the palette depth are dropped
            if (idx < rptt_pkg::PALETTE_DEPTH) begin
               pal_rgba[idx]  = rgba;
               pal_known[idx] = 1'b1;
            end
         end
         rptt_pkg::OP_START: begin
            col_now  = '0;
            row_now  = '0;
            done_now = '0;
            err_now  = 1'b0;
         end
         rptt_pkg::OP_FINISH: begin
            push_result('0, '0, (!err_now && int'(done_now) == total) ?
                        rptt_pkg::ST_COMPLETE : rptt_pkg::ST_INCOMPLETE, 1'b1);
         end
         rptt_pkg::OP_RUN: begin
            if (!err_now) begin
               if (n > rptt_pkg::MAX_RUN) n = rptt_pkg::MAX_RUN;
               // index check wins over the overflow check, even for empty runs
               if (idx >= entries_reg || idx >= rptt_pkg::PALETTE_DEPTH) begin
                  err_now = 1'b1;
                  push_result('0, '0, rptt_pkg::ST_BAD_INDEX, 1'b1);
               end else if (int'(done_now) + n > total) begin
                  err_now = 1'b1;
                  push_result('0, '0, rptt_pkg::ST_OVERFLOW, 1'b1);
               end else begin
                  for (int i = 0; i < n; i++) begin
                     push_result(swizzled_offset(col_now, row_now), pal_rgba[idx],
                                 rptt_pkg::ST_TEXEL, i == n - 1);
                     done_now = done_now + 1'b1;
                     // a column past a shrunk side still wraps after its texel
                     if (int'(col_now) + 1 >= side) begin
                        col_now = '0;
                        row_now = row_now + 1'b1;
                     end else begin
                        col_now = col_now + 1'b1;
                     end
                  end
               end
            end
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Input side. Called at a rising edge; returns at the edge that took the item.
   // Handshakes are sampled at the falling edge, where nothing is changing.
   // ---------------------------------------------------------------------------
   task automatic send_item(logic [1:0] op, logic [6:0] len, logic [7:0] idx,
                            logic [31:0] rgba);
      int gap;
      bit taken;
      gap = 0;
      if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (!(op == rptt_pkg::OP_WRITE && idx >= rptt_pkg::PALETTE_DEPTH) &&
          !(op == rptt_pkg::OP_RUN && err_now))
         items_used++;
      predict_item(op, len, idx, rgba);
      req_valid       <= 1'b1;
      req_op          <= op;
      req_run_length  <= len;
      req_color_index <= idx;
      req_entry_red   <= rgba[7:0];
      req_entry_green <= rgba[15:8];
      req_entry_blue  <= rgba[23:16];
      req_entry_alpha <= rgba[31:24];
      forever begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
         if (taken) break;
      end
      items_sent++;
   endtask

   task automatic put_palette(logic [7:0] slot, logic [31:0] rgba);
      send_item(rptt_pkg::OP_WRITE, 7'($urandom_range(0, 127)), slot, rgba);
   endtask

   // an entry in range is always filled before a run may read it
   task automatic send_run(logic [6:0] len, logic [7:0] idx);
      if (idx < rptt_pkg::PALETTE_DEPTH && !pal_known[idx]) put_palette(idx, $urandom);
      send_item(rptt_pkg::OP_RUN, len, idx, $urandom);
   endtask

   task automatic send_finish();
      send_item(rptt_pkg::OP_FINISH, 7'($urandom_range(0, 127)),
                8'($urandom_range(0, 255)), $urandom);
   endtask

   task automatic send_start();
      send_item(rptt_pkg::OP_START, 7'($urandom_range(0, 127)),
                8'($urandom_range(0, 255)), $urandom);
   endtask

   // wait until every owed result is out and the back end has gone quiet
   task automatic drain();
      req_valid <= 1'b0;
      while (texel_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Register port: setup phase then access phase, and the bus returns to idle after each transfer.
   // ---------------------------------------------------------------------------
   task automatic reg_write(logic sel, logic [31:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {sel, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (sel == rptt_pkg::REG_IMAGE_SIDE) side_reg = val[6:0];
      else entries_reg = val[5:0];
      reg_writes++;
      @(posedge clock);
   endtask

   task automatic reg_check(logic sel, logic [31:0] want);
      logic [31:0] got;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {sel, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      got = prdata;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      check_field("register readback", want, got);
      @(posedge clock);
   endtask

   // new image_side and palette_entries, only with the block idle
   task automatic program_regs(int side, int entries);
      drain();
      reg_write(rptt_pkg::REG_IMAGE_SIDE, 32'(side));
      reg_check(rptt_pkg::REG_IMAGE_SIDE, 32'(side_reg));
      reg_write(rptt_pkg::REG_PALETTE_ENTRIES, 32'(entries));
      reg_check(rptt_pkg::REG_PALETTE_ENTRIES, 32'(entries_reg));
   endtask

   // ---------------------------------------------------------------------------
   // Output side: random stalls in bursts, and the checker.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 7);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready  <= 1'b1;
      end
   end

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endfunction

   // valid and ready are stable mid-cycle, so an item seen here is taken at the next edge
   always @(negedge clock) begin
      texel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (texel_q.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("%0t: unexpected result, expected none actual status %0d offset %0h",
                        $time, rsp_status, rsp_texel_offset);
         end else begin
            want = texel_q.pop_front();
            check_field("texel_offset", want.offset, rsp_texel_offset);
            check_field("red", want.red, rsp_red);
            check_field("green", want.green, rsp_green);
            check_field("blue", want.blue, rsp_blue);
            check_field("alpha", want.alpha, rsp_alpha);
            check_field("status", want.status, rsp_status);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run stopped at the cycle limit, %0d results still owed",
                  $time, texel_q.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // register reset values, an early finish, then a short run at the reset image size
   task automatic test_reset_state();
      reg_check(rptt_pkg::REG_IMAGE_SIDE, 32'(rptt_pkg::IMAGE_SIDE_RESET));
      reg_check(rptt_pkg::REG_PALETTE_ENTRIES, 32'(rptt_pkg::PALETTE_ENTRIES_RESET));
      send_finish();                  // nothing drawn: incomplete
      send_run(7'd5, 8'd21);          // top valid index at reset
   endtask

   // palette extremes, ignored slots, empty and long runs, both errors
   task automatic test_runs_and_errors();
      program_regs(4, 63);            // entries above depth: depth limits the index
      put_palette(8'd0, 32'hFFFF_FFFF);
      put_palette(8'd31, 32'h0000_0000);
      put_palette(8'd200, 32'h1234_5678);   // dropped
      put_palette(8'd255, 32'hA5A5_A5A5);   // dropped
      send_start();
      send_run(7'd0, 8'd0);           // empty run, nothing out
      send_run(7'd5, 8'd0);
      send_run(7'd11, 8'd31);         // fills the 4x4 image exactly
      send_finish();                  // complete
      send_run(7'd1, 8'd0);           // one past the end: overflow
      send_finish();                  // error set: incomplete
      send_start();
      send_run(7'd3, 8'd32);          // past palette depth: bad index
      send_run(7'd3, 8'd0);           // dropped while the error stands
      send_finish();
      send_start();
      send_run(7'd127, 8'd31);        // clips to 64, still overflows 16
      send_start();
      send_run(7'd0, 8'd255);         // empty but bad index still errors
   endtask

   // image_side 0 and above 64, palette_entries 0 and 1
   task automatic test_size_extremes();
      program_regs(0, 1);
      send_start();
      send_run(7'd1, 8'd1);           // index 1 with one entry: bad
      send_start();
      send_run(7'd1, 8'd0);           // side acts as 1: one texel at offset 0
      send_finish();
      program_regs(127, 0);
      send_start();
      send_run(7'd4, 8'd0);           // no valid entries at all
      program_regs(127, 32);
      send_start();
      send_run(7'd64, 8'd31);         // full first row of a 64-wide image
      send_run(7'd127, 8'd0);
      send_finish();
   endtask

   // side shrinks with the column already past it, then the image completes
   task automatic test_side_change();
      program_regs(16, 32);
      send_start();
      send_run(7'd10, 8'd2);
      program_regs(5, 32);            // column 10 is past the new side
      send_run(7'd8, 8'd3);
      send_finish();                  // 18 of 25
      send_run(7'd7, 8'd4);
      send_finish();                  // 25 of 25: complete
      program_regs(3, 32);
      send_run(7'd1, 8'd0);           // 26 > 9: overflow
   endtask

   // a well-formed image: runs that fill what is left, peeks, then a finish
   task automatic clean_image();
      int left;
      int len;
      int top_idx;
      repeat ($urandom_range(0, 3)) put_palette(8'($urandom_range(0, 31)), $urandom);
      top_idx = (entries_reg < rptt_pkg::PALETTE_DEPTH) ? int'(entries_reg) :
                rptt_pkg::PALETTE_DEPTH;
      left = side_eff() * side_eff() - int'(done_now);
      while (left > 0 && top_idx > 0) begin
         len = $urandom_range(1, (left < rptt_pkg::MAX_RUN) ? left : rptt_pkg::MAX_RUN);
         send_run(7'(len), 8'($urandom_range(0, top_idx - 1)));
         left -= len;
         if ($urandom_range(0, 15) == 0) send_finish();
      end
      send_finish();
   endtask

   // anything goes: every op with fields over their full width
   task automatic noise_burst();
      repeat ($urandom_range(4, 12)) begin
         case (2'($urandom_range(0, 3)))
            rptt_pkg::OP_WRITE:  put_palette(8'($urandom_range(0, 255)), $urandom);
            rptt_pkg::OP_RUN: begin
               if ($urandom_range(0, 1) == 0)
                  send_run(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
               else
                  send_run(7'($urandom_range(0, 127)), 8'($urandom_range(0, 31)));
            end
            rptt_pkg::OP_FINISH: send_finish();
            rptt_pkg::OP_START:  send_start();
         endcase
      end
   endtask

   // mostly small images, a few large or out-of-range sides
   task automatic test_random_images(int count);
      int base;
      int pick;
      int side;
      int entries;
      base = items_used;
      while (items_used - base < count) begin
         pick = $urandom_range(0, 19);
         if (pick < 12)      side = $urandom_range(1, 8);
         else if (pick < 16) side = $urandom_range(9, 24);
         else if (pick < 18) side = $urandom_range(25, 64);
         else if (pick < 19) side = $urandom_range(65, 127);
         else                side = 0;
         pick = $urandom_range(0, 9);
         if (pick == 0)      entries = 0;
         else if (pick == 1) entries = 63;
         else if (pick == 2) entries = 32;
         else if (pick == 3) entries = 1;
         else                entries = $urandom_range(1, 40);
         program_regs(side, entries);
         // now and then the counters carry over into the new size
         if ($urandom_range(0, 5) != 0) send_start();
         if ($urandom_range(0, 3) != 0) clean_image();
         else noise_burst();
      end
   endtask

   // whole 64x64 texture, reaching the last tile and texel
   task automatic test_full_texture();
      program_regs(64, 32);
      send_start();
      repeat (rptt_pkg::TEXTURE_SIDE) send_run(7'd64, 8'($urandom_range(0, 31)));
      send_finish();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_runs_and_errors();
      test_size_extremes();
      test_side_change();
      test_random_images(RANDOM_ITEMS);

      // closing part runs with both sides flat out
      idle_on = 1'b0;
      test_full_texture();
      test_random_images(CLOSING_ITEMS);

      drain();
      repeat (4 * SETTLE_CYCLES) @(posedge clock);
      $display("Summary: %0d items sent (%0d acted on), %0d results checked,",
               items_sent, items_used, results_seen);
      $display("         %0d register writes, %0d cycles, %0d mismatches",
               reg_writes, cycle_count, fail_count);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
